// ===== rtl/rle_count_string_decoder_macros.svh =====
// assertion macros used by the top-level decoder, the only file that asserts
`ifndef RLE_COUNT_STRING_DECODER_MACROS_SVH
`define RLE_COUNT_STRING_DECODER_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define RCSD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCSD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/rcsd_pkg.sv =====
package rcsd_pkg;

   localparam int unsigned CHAR_WIDTH          = 8;
   localparam int unsigned RUN_WIDTH           = 63;
   localparam int unsigned ACC_WIDTH           = 64;
   localparam int unsigned SHIFT_WIDTH         = $clog2(ACC_WIDTH);
   localparam int unsigned COUNT_WIDTH         = 4;
   localparam int unsigned DIGIT_BITS          = 5;
   localparam int unsigned RUNS_WIDTH          = 2;
   localparam int unsigned MAX_DIGITS_DEFAULT  = 13;
   localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [CHAR_WIDTH-1:0] CHAR_OFFSET = 8'd48;
   localparam logic [RUNS_WIDTH-1:0] RUNS_SAT    = 2'd3;

   // one classified character on its way to the back end
   typedef struct packed {
      logic [DIGIT_BITS-1:0] data;
      logic                  more;
      logic                  last_char;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // sign fill above the digits once digit number digits+1 is the final one
   function automatic logic [ACC_WIDTH-1:0] sign_mask(input logic [COUNT_WIDTH-1:0] digits);
      int unsigned shift;
      shift = DIGIT_BITS * (int'(digits) + 1);
      if (shift < ACC_WIDTH) begin
         return {ACC_WIDTH{1'b1}} << shift;
      end else begin
         return '0;
      end
   endfunction

endpackage

// ===== rtl/rcsd_if.sv =====
interface rcsd_req_if import rcsd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CHAR_WIDTH-1:0] char_code;
   logic                  end_of_string;

   modport source (output valid, output char_code, output end_of_string, input ready);
   modport sink   (input valid, input char_code, input end_of_string, output ready);
endinterface

interface rcsd_rsp_if import rcsd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [RUN_WIDTH-1:0] run_length;
   logic                 error;
   logic                 last;

   modport source (output valid, output run_length, output error, output last, input ready);
   modport sink   (input valid, input run_length, input error, input last, output ready);
endinterface

// ===== rtl/rle_count_string_decoder.sv =====
// path: each accepted item is stored in the queue, then the back end registers the result
// throughput: one item per cycle unless a stalled result holds the back end; the
//   decode step there is digit merge plus the 64-bit add of the run two places back
// reset: synchronous, active high; clears the queue pointers, the decode state
//   and the output valid flag at once, no clearing pass
`include "rle_count_string_decoder_macros.svh"

module rle_count_string_decoder import rcsd_pkg::*; #(
   parameter int unsigned MAX_DIGITS  = MAX_DIGITS_DEFAULT,
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   rcsd_req_if.sink   req_chan,
   rcsd_rsp_if.source rsp_chan
);

   // front to queue
   logic      push;
   entry_type push_data;
   // queue to back
   logic      pop;
   entry_type pop_data;
   qstat_type q_status;

   // front end: takes each item, splits the offset byte into digit bits and
   // continue flag, and passes on the end-of-string flag
   rcsd_front u_front (
      .req_chan  (req_chan),
      .q_status  (q_status),
      .push      (push),
      .push_data (push_data)
   );

   // short queue so a stalled result side does not stall the input at once
   rcsd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (q_status)
   );

   // back end: accumulates digits, sign extension, delta against the run
   // two back, error and drop handling, registered result
   rcsd_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_status (q_status),
      .entry    (pop_data),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

   // an accepted item is in the queue on the next cycle
   `RCSD_ASSERT_NXT(a_item_queued, push, !q_status.empty, "accepted item missing from queue")

   // a result held back by the sink must stop the decode step
   `RCSD_ASSERT_IMP(a_stall_holds_back, rsp_chan.valid && !rsp_chan.ready, !pop,
      "decode step taken while result stalled")

   // error results carry a zero run length
   `RCSD_ASSERT_IMP(a_error_zero_run, rsp_chan.valid && rsp_chan.error,
      rsp_chan.run_length == '0, "error result with nonzero run length")

endmodule

// ===== rtl/rcsd_front.sv =====
module rcsd_front import rcsd_pkg::*; (
   rcsd_req_if.sink  req_chan,
   input  qstat_type q_status,
   output logic      push,
   output entry_type push_data
);

   logic [CHAR_WIDTH-1:0] offset_code;

   // take items whenever the queue has room
   assign req_chan.ready = !q_status.full;
   assign push           = req_chan.valid && req_chan.ready;

   // character minus offset, wraps mod 256
   assign offset_code = req_chan.char_code - CHAR_OFFSET;

   always_comb begin
      push_data.data      = offset_code[DIGIT_BITS-1:0];
      push_data.more      = offset_code[DIGIT_BITS];
      push_data.last_char = req_chan.end_of_string;
   end

endmodule

// ===== rtl/rcsd_queue.sv =====
module rcsd_queue import rcsd_pkg::*; #(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_data,
   input  logic      pop,
   output entry_type pop_data,
   output qstat_type status
);

   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR = PTR_WIDTH'(DEPTH - 1);
   localparam logic [CNT_WIDTH-1:0] FULL_CNT = CNT_WIDTH'(DEPTH);

   entry_type              slot_ff [DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign status.empty = (count_ff == '0);
   assign status.full  = (count_ff == FULL_CNT);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/rcsd_back.sv =====
module rcsd_back import rcsd_pkg::*; #(
   parameter int unsigned MAX_DIGITS = MAX_DIGITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  qstat_type  q_status,
   input  entry_type  entry,
   output logic       pop,
   rcsd_rsp_if.source rsp_chan
);

   localparam logic [COUNT_WIDTH-1:0] MAX_COUNT = COUNT_WIDTH'(MAX_DIGITS);

   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic [COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [ACC_WIDTH-1:0]   prev_ff, prev_in;
   logic [ACC_WIDTH-1:0]   prev2_ff, prev2_in;
   logic [RUNS_WIDTH-1:0]  runs_ff, runs_in;
   logic                   drop_ff, drop_in;
   logic                   valid_ff, valid_in;
   logic [RUN_WIDTH-1:0]   run_ff, run_in;
   logic                   err_ff, err_in;
   logic                   last_ff, last_in;

   logic [SHIFT_WIDTH-1:0] digit_shift;
   logic [ACC_WIDTH-1:0]   acc_merge;
   logic [ACC_WIDTH-1:0]   value;

   assign rsp_chan.valid      = valid_ff;
   assign rsp_chan.run_length = run_ff;
   assign rsp_chan.error      = err_ff;
   assign rsp_chan.last       = last_ff;

   // step when the output register is free or being emptied
   assign pop = !q_status.empty && (!valid_ff || rsp_chan.ready);

   assign digit_shift = SHIFT_WIDTH'(DIGIT_BITS * int'(cnt_ff));

   always_comb begin
      acc_merge = acc_ff | (ACC_WIDTH'(entry.data) << digit_shift);
      if (!entry.more && entry.data[DIGIT_BITS-1]) begin
         acc_merge = acc_merge | sign_mask(cnt_ff);
      end
      value = acc_merge + ((runs_ff == RUNS_SAT) ? prev2_ff : '0);
   end

   always_comb begin
      acc_in   = acc_ff;
      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      prev2_in = prev2_ff;
      runs_in  = runs_ff;
      drop_in  = drop_ff;
      valid_in = valid_ff && !rsp_chan.ready;
      run_in   = run_ff;
      err_in   = err_ff;
      last_in  = last_ff;
      if (pop) begin
         if (!drop_ff && cnt_ff >= MAX_COUNT) begin
            // too many digits
            valid_in = 1'b1;
            run_in   = '0;
            err_in   = 1'b1;
            last_in  = entry.last_char;
            acc_in   = '0;
            cnt_in   = '0;
            drop_in  = 1'b1;
         end else if (!drop_ff && entry.more && !entry.last_char) begin
            acc_in = acc_merge;
            cnt_in = cnt_ff + 1'b1;
         end else if (!drop_ff) begin
            valid_in = 1'b1;
            last_in  = entry.last_char;
            acc_in   = '0;
            cnt_in   = '0;
            if (value[ACC_WIDTH-1]) begin
               // negative run
               run_in  = '0;
               err_in  = 1'b1;
               drop_in = 1'b1;
            end else begin
               run_in   = value[RUN_WIDTH-1:0];
               err_in   = 1'b0;
               prev2_in = prev_ff;
               prev_in  = value;
               if (runs_ff != RUNS_SAT) begin
                  runs_in = runs_ff + 1'b1;
               end
            end
         end
         // end of string returns everything to the start state
         if (entry.last_char) begin
            acc_in   = '0;
            cnt_in   = '0;
            prev_in  = '0;
            prev2_in = '0;
            runs_in  = '0;
            drop_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         cnt_ff   <= '0;
         prev_ff  <= '0;
         prev2_ff <= '0;
         runs_ff  <= '0;
         drop_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         cnt_ff   <= cnt_in;
         prev_ff  <= prev_in;
         prev2_ff <= prev2_in;
         runs_ff  <= runs_in;
         drop_ff  <= drop_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      run_ff  <= run_in;
      err_ff  <= err_in;
      last_ff <= last_in;
   end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import rcsd_pkg::*;

   // fields of one byte after the offset is taken off
   localparam logic [7:0] DATA_MASK = 8'h1F;
   localparam logic [7:0] SIGN_FLAG = 8'h10;
   localparam logic [7:0] MORE_FLAG = 8'h20;

   localparam int unsigned MAX_RUN_DIGITS = MAX_DIGITS_DEFAULT;
   localparam int unsigned STALL_LIMIT    = 2000;  // cycles with no item moving on either side
   localparam int unsigned DRAIN_CYCLES   = 10;    // wait for stray results after the last expected one
   localparam int unsigned PRINT_LIMIT    = 50;

   typedef struct packed {
      logic [RUN_WIDTH-1:0] run_length;
      logic                 error;
      logic                 last;
   } run_result_type;

   logic clock;
   logic reset;

   rcsd_req_if req_chan ();
   rcsd_rsp_if rsp_chan ();

   rle_count_string_decoder #(.MAX_DIGITS(MAX_RUN_DIGITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // decoder state as the block should hold it
   logic [ACC_WIDTH-1:0]   value_acc;
   logic [COUNT_WIDTH-1:0] value_digits;
   logic [ACC_WIDTH-1:0]   last_run;
   logic [ACC_WIDTH-1:0]   run_before_last;
   logic [RUNS_WIDTH-1:0]  runs_seen;
   logic                   skipping_string;

   run_result_type pending_runs[$];

   int unsigned accepted_chars;  // items taken by the block, dropped ones included
   int unsigned results_seen;
   int unsigned fail_count;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;

   function automatic void clear_decoder_state();
      value_acc       = '0;
      value_digits    = '0;
      last_run        = '0;
      run_before_last = '0;
      runs_seen       = '0;
      skipping_string = 1'b0;
   endfunction

   function automatic void expect_run(input logic [ACC_WIDTH-1:0] run, input logic err,
                                      input logic eos);
      run_result_type r;
      r.run_length = run[RUN_WIDTH-1:0];
      r.error      = err;
      r.last       = eos;
      pending_runs = {pending_runs, r};
   endfunction

   // works out what one accepted byte does to the decoder and what it emits
   function automatic void decode_char(input logic [7:0] code, input logic eos);
      logic [7:0]           c;
      logic                 more;
      int unsigned          fill_shift;
      logic [ACC_WIDTH-1:0] total;
      c    = code - CHAR_OFFSET;
      more = (c & MORE_FLAG) != 0;
      accepted_chars++;
      // after an error the rest of the string is thrown away
      if (skipping_string) begin
         if (eos) clear_decoder_state();
         return;
      end
      // one digit too many for a single value
      if (value_digits >= MAX_RUN_DIGITS) begin
         expect_run('0, 1'b1, eos);
         if (eos) begin
            clear_decoder_state();
         end else begin
            value_acc       = '0;
            value_digits    = '0;
            skipping_string = 1'b1;
         end
         return;
      end
      value_acc  = value_acc | (ACC_WIDTH'(c & DATA_MASK) << (DIGIT_BITS * value_digits));
      fill_shift = DIGIT_BITS * (value_digits + 1);
      // sign fill only on a true final digit, and only if it lands inside 64 bits
      if (!more && (c & SIGN_FLAG) != 0 && fill_shift < ACC_WIDTH)
         value_acc = value_acc | ({ACC_WIDTH{1'b1}} << fill_shift);
      if (more && !eos) begin
         value_digits++;
         return;
      end
      // value complete; from the fourth run on it is a delta against two runs back
      total = value_acc;
      if (runs_seen >= RUNS_SAT) total = total + run_before_last;
      value_acc    = '0;
      value_digits = '0;
      if (total[ACC_WIDTH-1]) begin
         expect_run('0, 1'b1, eos);
         if (eos) clear_decoder_state();
         else skipping_string = 1'b1;
         return;
      end
      expect_run(total, 1'b0, eos);
      run_before_last = last_run;
      last_run        = total;
      if (runs_seen < RUNS_SAT) runs_seen++;
      if (eos) clear_decoder_state();
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_count++;
      // keep the log short when the block is badly off
      if (fail_count <= PRINT_LIMIT)
         $display("result %0d: %s is %0h, expected %0h", results_seen, field, got, want);
   endtask

   // one byte offered to the block; valid is only dropped when the sender idles,
   // so back-to-back items keep it high without a second assignment in a step
   task automatic send_char(input logic [7:0] code, input logic eos);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.char_code     <= code;
      req_chan.end_of_string <= eos;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      decode_char(code, eos);
   endtask

   // byte for a digit, with the two unused top bits filled at random
   function automatic logic [7:0] digit_char(input logic [4:0] data, input logic more);
      logic [7:0] c;
      c = {2'($urandom_range(0, 3)), more, data};
      return c + CHAR_OFFSET;
   endfunction

   // byte 0 decodes to a sign-filled final digit, so each is a negative run;
   // byte 255 decodes to a plain final digit of 15
   task automatic test_error_paths();
      send_char(8'd0, 1'b1);     // negative run on the last byte
      send_char(8'd0, 1'b0);     // negative run mid-string, rest is dropped
      send_char(8'd255, 1'b1);   // dropped last byte just clears the state
      send_char(8'd255, 1'b1);   // one-digit string of 15
   endtask

   // runs 1, 2, 3, then -1 + 2 and a last byte with its continue bit set: 5 + 3
   task automatic test_run_addition();
      send_char(CHAR_OFFSET + 8'd1, 1'b0);
      send_char(CHAR_OFFSET + 8'd2, 1'b0);
      send_char(CHAR_OFFSET + 8'd3, 1'b0);
      send_char(CHAR_OFFSET + (DATA_MASK | SIGN_FLAG), 1'b0);
      send_char(CHAR_OFFSET + (MORE_FLAG | 8'd5), 1'b1);
   endtask

   // thirteen digits: the sign bit of the last one falls beyond bit 63
   task automatic test_wide_sign_extension();
      repeat (MAX_RUN_DIGITS - 1) send_char(CHAR_OFFSET + (MORE_FLAG | DATA_MASK), 1'b0);
      send_char(CHAR_OFFSET + SIGN_FLAG, 1'b1);
   endtask

   // one value of a count string: mostly short, some long, a few too long
   task automatic send_value(input logic final_run, input logic is_delta);
      int unsigned n_digits;
      int unsigned pick;
      logic        cut;
      logic        more;
      logic [4:0]  data;
      pick = $urandom_range(0, 99);
      if (pick < 70) n_digits = $urandom_range(1, 3);
      else if (pick < 95) n_digits = $urandom_range(4, MAX_RUN_DIGITS);
      else n_digits = $urandom_range(MAX_RUN_DIGITS + 1, MAX_RUN_DIGITS + 3);
      // now and then the string ends on a digit that still asks for more
      cut = final_run && ($urandom_range(0, 9) == 0);
      for (int unsigned i = 0; i < n_digits; i++) begin
         data = 5'($urandom_range(0, 31));
         more = (i != n_digits - 1) || cut;
         if (!more) begin
            // deltas are often negative, plain runs hardly ever
            if (is_delta) data[4] = ($urandom_range(0, 99) < 45);
            else data[4] = ($urandom_range(0, 99) < 4);
         end
         send_char(digit_char(data, more), final_run && (i == n_digits - 1));
      end
   endtask

   task automatic send_count_string();
      int unsigned n_runs;
      if ($urandom_range(0, 9) == 0) n_runs = $urandom_range(6, 24);
      else n_runs = $urandom_range(1, 6);
      for (int unsigned r = 0; r < n_runs; r++)
         send_value(r == n_runs - 1, r >= RUNS_SAT);
   endtask

   // raw bytes, may end a string anywhere or leave one open
   task automatic send_noise();
      repeat ($urandom_range(1, 8))
         send_char(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 25);
   endtask

   task automatic test_random_strings(input int unsigned n_chars);
      int unsigned target;
      target = accepted_chars + n_chars;
      while (accepted_chars < target) begin
         if ($urandom_range(0, 99) < 12) send_noise();
         else send_count_string();
      end
   endtask

   // result side: random back-pressure, each taken item checked against the oldest expectation
   always @(posedge clock) begin : check_results
      run_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            results_seen++;
            if (pending_runs.size() == 0) begin
               report_mismatch("unexpected item, run_length", 64'(rsp_chan.run_length), '0);
            end else begin
               want = pending_runs.pop_front();
               if (rsp_chan.run_length !== want.run_length)
                  report_mismatch("run_length", 64'(rsp_chan.run_length), 64'(want.run_length));
               if (rsp_chan.error !== want.error)
                  report_mismatch("error", 64'(rsp_chan.error), 64'(want.error));
               if (rsp_chan.last !== want.last)
                  report_mismatch("last", 64'(rsp_chan.last), 64'(want.last));
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // watchdog: gives up once no item has moved for too long
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      wait (reset === 1'b1);
      wait (reset === 1'b0);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
             (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("rle_count_string_decoder: mismatch");
      $finish;
   end

   initial begin
      req_chan.valid         <= 1'b0;
      req_chan.char_code     <= '0;
      req_chan.end_of_string <= 1'b0;
      reset                  <= 1'b1;
      accepted_chars = 0;
      results_seen   = 0;
      fail_count     = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      clear_decoder_state();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // sender idles a third of the time, receiver mostly stalls
      send_idle_pct  = 33;
      recv_stall_pct = 76;
      test_error_paths();
      test_run_addition();
      test_wide_sign_extension();
      test_random_strings(620);

      // sender mostly idle, receiver stalls now and then
      send_idle_pct  = 76;
      recv_stall_pct = 33;
      test_random_strings(630);

      // full rate on both sides
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_random_strings(630);

      req_chan.valid <= 1'b0;
      while (pending_runs.size() != 0) @(posedge clock);
      // catch any stray item after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("rle_count_string_decoder: match");
      else
         $display("rle_count_string_decoder: mismatch");
      $finish;
   end

endmodule
